FILE: hw/rtl/hhlp_pkg.sv
package hhlp_pkg;

    // Offsets are reported in 12 bits, so the line cap never exceeds this
    localparam int OFFSET_LIMIT        = 4096;
    localparam int MAX_LINE_LENGTH_DEF = 4096;

    // Field widths of the result
    localparam int KIND_W   = 3;
    localparam int CODE_W   = 10;
    localparam int OFFSET_W = 12;

    // Line kinds
    localparam logic [KIND_W-1:0] KIND_BLANK   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INFO    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FINAL   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REPEAT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FIELD   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_IGNORED = 3'd5;

    // Bytes of interest
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SP    = 8'h20;
    localparam logic [7:0] CHAR_HTAB  = 8'h09;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    // One reported line
    typedef struct packed {
        logic [KIND_W-1:0]   line_kind;
        logic [CODE_W-1:0]   status_code;
        logic [OFFSET_W-1:0] name_start;
        logic [OFFSET_W-1:0] name_length;
        logic [OFFSET_W-1:0] value_start;
        logic [OFFSET_W-1:0] value_length;
        logic                line_overflow;
    } hhlp_result_t;

endpackage

FILE: hw/rtl/hhlp_in_if.sv
interface hhlp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       new_response;

    modport source (output valid, output data_byte, output new_response, input ready);
    modport sink   (input valid, input data_byte, input new_response, output ready);
endinterface

FILE: hw/rtl/hhlp_out_if.sv
interface hhlp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  line_kind;
    logic [9:0]  status_code;
    logic [11:0] name_start;
    logic [11:0] name_length;
    logic [11:0] value_start;
    logic [11:0] value_length;
    logic        line_overflow;

    modport source (output valid, output line_kind, output status_code,
                    output name_start, output name_length, output value_start,
                    output value_length, output line_overflow, input ready);
    modport sink   (input valid, input line_kind, input status_code,
                    input name_start, input name_length, input value_start,
                    input value_length, input line_overflow, output ready);
endinterface

FILE: hw/rtl/hhlp_line_core.sv
module hhlp_line_core #(
    parameter int MAX_LINE_LENGTH = hhlp_pkg::MAX_LINE_LENGTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           data_byte,
    input  logic                 new_response,
    output logic                 res_valid,
    output hhlp_pkg::hhlp_result_t res
);
    import hhlp_pkg::*;

    localparam int LINE_CAP = (MAX_LINE_LENGTH < OFFSET_LIMIT) ? MAX_LINE_LENGTH
                                                               : OFFSET_LIMIT;
    localparam int POS_W = $clog2(LINE_CAP + 1);
    localparam int OFS_W = $clog2(LINE_CAP);
    localparam int CR_W  = $clog2(LINE_CAP + 2);

    localparam logic [POS_W-1:0] CAP_POS = POS_W'(LINE_CAP);
    localparam logic [CR_W-1:0]  CR_SAT  = CR_W'(LINE_CAP + 1);

    // Status line recogniser codes; prefix match runs through 0..4
    localparam logic [3:0] PH_START = 4'd0;
    localparam logic [3:0] PH_VER   = 4'd5;
    localparam logic [3:0] PH_SP    = 4'd6;
    localparam logic [3:0] PH_D1    = 4'd7;
    localparam logic [3:0] PH_D2    = 4'd8;
    localparam logic [3:0] PH_DONE  = 4'd9;
    localparam logic [3:0] PH_FAIL  = 4'd10;

    function automatic logic [7:0] prefix_char(input logic [3:0] ph);
        logic [7:0] c;
        unique case (ph)
            4'd0:    c = 8'h48;
            4'd1:    c = 8'h54;
            4'd2:    c = 8'h54;
            4'd3:    c = 8'h50;
            default: c = 8'h2F;
        endcase
        return c;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic [3:0] next_phase(input logic [3:0] ph, input logic [7:0] b);
        logic [3:0] n;
        n = ph;
        if (ph < PH_VER)
        begin
            n = (b == prefix_char(ph)) ? ph + 4'd1 : PH_FAIL;
        end
        else
        begin
            unique case (ph)
                PH_VER:  n = (b == CHAR_SP) ? PH_SP : PH_VER;
                PH_SP:   n = (b == CHAR_SP) ? PH_SP : (is_digit(b) ? PH_D1 : PH_FAIL);
                PH_D1:   n = is_digit(b) ? PH_D2 : PH_FAIL;
                PH_D2:   n = is_digit(b) ? PH_DONE : PH_FAIL;
                default: n = ph;
            endcase
        end
        return n;
    endfunction

    function automatic logic [CODE_W-1:0] next_acc(input logic [3:0] ph,
                                                   input logic [CODE_W-1:0] acc,
                                                   input logic [7:0] b);
        logic [CODE_W-1:0] d;
        logic [CODE_W-1:0] n;
        d = CODE_W'(b - 8'h30);
        n = acc;
        if (is_digit(b))
        begin
            if (ph == PH_SP)
                n = d;
            else if (ph == PH_D1 || ph == PH_D2)
                n = CODE_W'(acc * 10) + d;
        end
        return n;
    endfunction

    // Line and section state
    logic              info_reg, info_next;
    logic              final_reg, final_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [3:0]        phase_reg, phase_next;
    logic [CODE_W-1:0] acc_reg, acc_next;
    logic              colon_reg, colon_next;
    logic [OFS_W-1:0]  nfirst_reg, nfirst_next;
    logic [OFS_W-1:0]  nlast_reg, nlast_next;
    logic              nany_reg, nany_next;
    logic [OFS_W-1:0]  vfirst_reg, vfirst_next;
    logic [OFS_W-1:0]  vlast_reg, vlast_next;
    logic              vany_reg, vany_next;
    logic [CR_W-1:0]   cr_reg, cr_next;
    logic              ovf_reg, ovf_next;

    logic [POS_W-1:0]  room;
    logic [POS_W-1:0]  k;
    logic [POS_W-1:0]  span_end;
    logic [POS_W-1:0]  name_len;
    logic [POS_W-1:0]  value_len;
    logic              ows;
    logic              code_ok;

    // Per-byte update: commit pending CRs, then the byte itself, or report at LF
    always_comb
    begin
        info_next   = info_reg;
        final_next  = final_reg;
        pos_next    = pos_reg;
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        colon_next  = colon_reg;
        nfirst_next = nfirst_reg;
        nlast_next  = nlast_reg;
        nany_next   = nany_reg;
        vfirst_next = vfirst_reg;
        vlast_next  = vlast_reg;
        vany_next   = vany_reg;
        cr_next     = cr_reg;
        ovf_next    = ovf_reg;
        res_valid   = 1'b0;
        res         = '0;

        room      = CAP_POS - pos_reg;
        k         = '0;
        span_end  = '0;
        ows       = (data_byte == CHAR_SP) || (data_byte == CHAR_HTAB);
        code_ok   = (phase_reg == PH_DONE) && (acc_reg >= CODE_W'(100))
                    && (acc_reg <= CODE_W'(599));
        name_len  = POS_W'(nlast_reg) - POS_W'(nfirst_reg) + POS_W'(1);
        value_len = POS_W'(vlast_reg) - POS_W'(vfirst_reg) + POS_W'(1);

        if (step)
        begin
            if (new_response)
            begin
                info_next  = 1'b0;
                final_next = 1'b0;
            end

            if (data_byte == CHAR_CR)
            begin
                // hold CR as pending, it may be part of the stripped run
                if (cr_reg != CR_SAT)
                    cr_next = cr_reg + CR_W'(1);
            end
            else if (data_byte != CHAR_LF)
            begin
                // pending CRs become ordinary bytes
                if (cr_reg > CR_W'(room))
                begin
                    ovf_next = 1'b1;
                    k        = room;
                end
                else
                begin
                    k = POS_W'(cr_reg);
                end
                if (k != '0)
                begin
                    phase_next = next_phase(phase_reg, CHAR_CR);
                    span_end   = pos_reg + k - POS_W'(1);
                    if (!colon_reg)
                    begin
                        if (!nany_reg)
                            nfirst_next = pos_reg[OFS_W-1:0];
                        nlast_next = span_end[OFS_W-1:0];
                        nany_next  = 1'b1;
                    end
                    else
                    begin
                        if (!vany_reg)
                            vfirst_next = pos_reg[OFS_W-1:0];
                        vlast_next = span_end[OFS_W-1:0];
                        vany_next  = 1'b1;
                    end
                    pos_next = pos_reg + k;
                end
                cr_next = '0;

                // the byte itself
                if (pos_next >= CAP_POS)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    acc_next   = next_acc(phase_next, acc_reg, data_byte);
                    phase_next = next_phase(phase_next, data_byte);
                    if (!colon_reg && data_byte == CHAR_COLON)
                    begin
                        colon_next = 1'b1;
                    end
                    else if (!ows)
                    begin
                        if (!colon_reg)
                        begin
                            if (!nany_next)
                                nfirst_next = pos_next[OFS_W-1:0];
                            nlast_next = pos_next[OFS_W-1:0];
                            nany_next  = 1'b1;
                        end
                        else
                        begin
                            if (!vany_next)
                                vfirst_next = pos_next[OFS_W-1:0];
                            vlast_next = pos_next[OFS_W-1:0];
                            vany_next  = 1'b1;
                        end
                    end
                    pos_next = pos_next + POS_W'(1);
                end
            end
            else
            begin
                // end of line: classify and report
                res_valid         = 1'b1;
                res.line_overflow = ovf_reg;
                if (pos_reg == '0)
                begin
                    info_next     = 1'b0;
                    res.line_kind = KIND_BLANK;
                end
                else if (code_ok)
                begin
                    res.status_code = acc_reg;
                    if (acc_reg < CODE_W'(200))
                    begin
                        info_next     = 1'b1;
                        res.line_kind = KIND_INFO;
                    end
                    else
                    begin
                        info_next     = 1'b0;
                        res.line_kind = final_next ? KIND_REPEAT : KIND_FINAL;
                        final_next    = 1'b1;
                    end
                end
                else if (info_next || !final_next || !colon_reg || !nany_reg)
                begin
                    res.line_kind = KIND_IGNORED;
                end
                else
                begin
                    res.line_kind   = KIND_FIELD;
                    res.name_start  = OFFSET_W'(nfirst_reg);
                    res.name_length = OFFSET_W'(name_len);
                    if (vany_reg)
                    begin
                        res.value_start  = OFFSET_W'(vfirst_reg);
                        res.value_length = OFFSET_W'(value_len);
                    end
                    else if (32'(pos_reg) > 4095)
                    begin
                        res.value_start = '1;
                    end
                    else
                    begin
                        res.value_start = OFFSET_W'(pos_reg);
                    end
                end

                pos_next    = '0;
                phase_next  = PH_START;
                acc_next    = '0;
                colon_next  = 1'b0;
                nfirst_next = '0;
                nlast_next  = '0;
                nany_next   = 1'b0;
                vfirst_next = '0;
                vlast_next  = '0;
                vany_next   = 1'b0;
                cr_next     = '0;
                ovf_next    = 1'b0;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            info_reg   <= 1'b0;
            final_reg  <= 1'b0;
            pos_reg    <= '0;
            phase_reg  <= PH_START;
            acc_reg    <= '0;
            colon_reg  <= 1'b0;
            nfirst_reg <= '0;
            nlast_reg  <= '0;
            nany_reg   <= 1'b0;
            vfirst_reg <= '0;
            vlast_reg  <= '0;
            vany_reg   <= 1'b0;
            cr_reg     <= '0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            info_reg   <= info_next;
            final_reg  <= final_next;
            pos_reg    <= pos_next;
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            colon_reg  <= colon_next;
            nfirst_reg <= nfirst_next;
            nlast_reg  <= nlast_next;
            nany_reg   <= nany_next;
            vfirst_reg <= vfirst_next;
            vlast_reg  <= vlast_next;
            vany_reg   <= vany_next;
            cr_reg     <= cr_next;
            ovf_reg    <= ovf_next;
        end
    end

endmodule

FILE: hw/rtl/http_header_line_parser.sv
// Channel  Dir  Payload                                      Request
// hdr      in   data_byte, new_response                      one header byte
// line     out  line_kind, status_code, name/value offsets,  one parsed line
//               line_overflow
//
// One byte is taken every cycle while the result side is not stalled; a result is
// presented once its LF has passed the input register and the byte update logic
// has loaded the result register. Other bytes give no result.
// rst_n clears all section and line state asynchronously.
// A stalled result holds the result register; one further byte waits in the
// input register, then hdr.ready drops.
module http_header_line_parser #(
    parameter int MAX_LINE_LENGTH = hhlp_pkg::MAX_LINE_LENGTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    hhlp_in_if.sink    hdr,
    hhlp_out_if.source line
);
    import hhlp_pkg::*;

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_byte_reg;
    logic         in_new_reg;
    logic         out_valid_reg, out_valid_next;
    hhlp_result_t out_reg;
    logic         step;
    logic         res_valid;
    hhlp_result_t res;

    // Pipeline advance
    assign step      = in_valid_reg && (!out_valid_reg || line.ready);
    assign hdr.ready = !in_valid_reg || step;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (hdr.ready)
            in_valid_next = hdr.valid;
        out_valid_next = out_valid_reg;
        if (!out_valid_reg || line.ready)
            out_valid_next = res_valid;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (hdr.valid && hdr.ready)
        begin
            in_byte_reg <= hdr.data_byte;
            in_new_reg  <= hdr.new_response;
        end
        if (res_valid)
            out_reg <= res;
    end

    hhlp_line_core #(
        .MAX_LINE_LENGTH (MAX_LINE_LENGTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .data_byte    (in_byte_reg),
        .new_response (in_new_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    assign line.valid         = out_valid_reg;
    assign line.line_kind     = out_reg.line_kind;
    assign line.status_code   = out_reg.status_code;
    assign line.name_start    = out_reg.name_start;
    assign line.name_length   = out_reg.name_length;
    assign line.value_start   = out_reg.value_start;
    assign line.value_length  = out_reg.value_length;
    assign line.line_overflow = out_reg.line_overflow;

`ifndef ASSERT_OFF
    // held byte is not lost while the result side stalls
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !step |=> in_valid_reg)
        else $error("input byte dropped during stall");

    // status code only on status lines
    a_code_kind: assert property (@(posedge clk) disable iff (!rst_n)
        line.valid && (line.line_kind == KIND_BLANK || line.line_kind == KIND_FIELD
                       || line.line_kind == KIND_IGNORED) |-> line.status_code == '0)
        else $error("status code on a non-status line");

    // offsets only on field lines
    a_offs_kind: assert property (@(posedge clk) disable iff (!rst_n)
        line.valid && line.line_kind != KIND_FIELD |->
            line.name_start == '0 && line.name_length == '0
            && line.value_start == '0 && line.value_length == '0)
        else $error("offsets on a non-field line");

    // a reported field always has a non-empty name
    a_field_name: assert property (@(posedge clk) disable iff (!rst_n)
        line.valid && line.line_kind == KIND_FIELD |-> line.name_length != '0)
        else $error("field line with empty name");
`endif

endmodule

FILE: verif/http_header_line_parser_tb.sv
`timescale 1ns / 100ps

module http_header_line_parser_tb;

    import hhlp_pkg::*;

    localparam int MAX_LEN  = MAX_LINE_LENGTH_DEF;
    localparam int LINE_CAP = (MAX_LEN < OFFSET_LIMIT) ? MAX_LEN : OFFSET_LIMIT;
    localparam int CR_SAT   = 4096;

    // Status line recogniser steps; 0..4 walk the "HTTP/" prefix
    localparam int STEP_VERSION = 5;
    localparam int STEP_SPACES  = 6;
    localparam int STEP_DIGIT1  = 7;
    localparam int STEP_DIGIT2  = 8;
    localparam int STEP_DONE    = 9;
    localparam int STEP_FAIL    = 10;

    localparam logic [39:0] HTTP_PREFIX = "HTTP/";
    localparam logic [7:0]  CHAR_0      = 8'h30;
    localparam logic [7:0]  CHAR_9      = 8'h39;

    typedef struct {
        logic [7:0] data_byte;
        logic       new_response;
    } header_byte_t;

    logic clk = 1'b0;
    logic rst_n;

    hhlp_in_if  hdr_ch();
    hhlp_out_if line_ch();

    http_header_line_parser #(
        .MAX_LINE_LENGTH (MAX_LEN)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .hdr   (hdr_ch),
        .line  (line_ch)
    );

    always #2 clk = ~clk;

    header_byte_t header_bytes_q[$];
    hhlp_result_t expected_lines[$];
    int           total_bytes = -1;
    int           bytes_taken = 0;
    int           mismatches  = 0;
    bit           hdr_taken   = 1'b0;
    bit           raise_new   = 1'b0;
    bit           stray_new   = 1'b0;
    int           send_gap    = 0;
    int           send_calm   = 0;
    int           stall_left  = 0;
    int           recv_calm   = 0;

    // Parser state as predicted from the accepted bytes
    bit          sect_informational;
    bit          sect_final_seen;
    int unsigned line_len;
    int unsigned status_step;
    int unsigned status_code_acc;
    bit          colon_found;
    int unsigned name_lo, name_hi;
    bit          name_found;
    int unsigned value_lo, value_hi;
    bit          value_found;
    int unsigned held_crs;
    bit          line_too_long;

    function automatic void clear_line_state();
        line_len        = 0;
        status_step     = 0;
        status_code_acc = 0;
        colon_found     = 1'b0;
        name_lo         = 0;
        name_hi         = 0;
        name_found      = 1'b0;
        value_lo        = 0;
        value_hi        = 0;
        value_found     = 1'b0;
        held_crs        = 0;
        line_too_long   = 1'b0;
    endfunction

    function automatic void step_status(logic [7:0] b);
        bit          digit;
        int unsigned d;
        digit = (b >= CHAR_0) && (b <= CHAR_9);
        d     = digit ? int'(b - CHAR_0) : 0;
        if (status_step < STEP_VERSION)
        begin
            status_step = (b == HTTP_PREFIX[39 - 8*status_step -: 8]) ? status_step + 1
                                                                     : STEP_FAIL;
        end
        else
        begin
            case (status_step)
                STEP_VERSION:
                begin
                    if (b == CHAR_SP)
                        status_step = STEP_SPACES;
                end
                STEP_SPACES:
                begin
                    if (b != CHAR_SP)
                    begin
                        if (digit)
                        begin
                            status_code_acc = d;
                            status_step     = STEP_DIGIT1;
                        end
                        else
                            status_step = STEP_FAIL;
                    end
                end
                STEP_DIGIT1, STEP_DIGIT2:
                begin
                    if (digit)
                    begin
                        status_code_acc = status_code_acc * 10 + d;
                        status_step = (status_step == STEP_DIGIT1) ? STEP_DIGIT2 : STEP_DONE;
                    end
                    else
                        status_step = STEP_FAIL;
                end
                default: ;
            endcase
        end
    endfunction

    // Non-OWS bytes at [pos, pos+k-1] widen the name span, or the value span after the colon
    function automatic void note_span(int unsigned pos, int unsigned k);
        if (!colon_found)
        begin
            if (!name_found)
                name_lo = pos;
            name_hi    = pos + k - 1;
            name_found = 1'b1;
        end
        else
        begin
            if (!value_found)
                value_lo = pos;
            value_hi    = pos + k - 1;
            value_found = 1'b1;
        end
    endfunction

    // Held CRs turned out to be part of the line
    function automatic void commit_held_crs(int unsigned n);
        int unsigned room, k;
        room = LINE_CAP - line_len;
        k    = (n < room) ? n : room;
        if (n > room)
            line_too_long = 1'b1;
        if (k != 0)
        begin
            step_status(CHAR_CR);
            note_span(line_len, k);
            line_len += k;
        end
    endfunction

    function automatic void parse_header_byte(input logic [7:0] b, input logic nr,
                                              output bit has_line, output hhlp_result_t res);
        has_line = 1'b0;
        res      = '0;
        if (nr)
        begin
            sect_informational = 1'b0;
            sect_final_seen    = 1'b0;
        end
        if (b == CHAR_CR)
        begin
            if (held_crs < CR_SAT)
                held_crs++;
        end
        else if (b != CHAR_LF)
        begin
            commit_held_crs(held_crs);
            held_crs = 0;
            if (line_len >= LINE_CAP)
                line_too_long = 1'b1;
            else
            begin
                step_status(b);
                if (!colon_found && b == CHAR_COLON)
                    colon_found = 1'b1;
                else if (b != CHAR_SP && b != CHAR_HTAB)
                    note_span(line_len, 1);
                line_len++;
            end
        end
        else
        begin
            // LF: classify the stripped line
            has_line          = 1'b1;
            res.line_overflow = line_too_long;
            if (line_len == 0)
            begin
                sect_informational = 1'b0;
                res.line_kind      = KIND_BLANK;
            end
            else if (status_step == STEP_DONE && status_code_acc >= 100
                     && status_code_acc <= 599)
            begin
                res.status_code = CODE_W'(status_code_acc);
                if (status_code_acc < 200)
                begin
                    sect_informational = 1'b1;
                    res.line_kind      = KIND_INFO;
                end
                else
                begin
                    sect_informational = 1'b0;
                    res.line_kind      = sect_final_seen ? KIND_REPEAT : KIND_FINAL;
                    sect_final_seen    = 1'b1;
                end
            end
            else if (sect_informational || !sect_final_seen || !colon_found || !name_found)
                res.line_kind = KIND_IGNORED;
            else
            begin
                res.line_kind   = KIND_FIELD;
                res.name_start  = OFFSET_W'(name_lo);
                res.name_length = OFFSET_W'(name_hi - name_lo + 1);
                if (value_found)
                begin
                    res.value_start  = OFFSET_W'(value_lo);
                    res.value_length = OFFSET_W'(value_hi - value_lo + 1);
                end
                else
                    res.value_start = (line_len > 4095) ? 12'd4095 : OFFSET_W'(line_len);
            end
            clear_line_state();
        end
    endfunction

    function automatic void check_field(string fname, int unsigned want, int unsigned seen);
        if (want != seen)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, seen);
            mismatches++;
        end
    endfunction

    // Mostly short idles, now and then a long one or a calm stretch with none
    function automatic int pick_idle(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm = $urandom_range(30, 120);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Stimulus building
    task automatic put_byte(logic [7:0] b);
        header_byte_t hb;
        hb.data_byte    = b;
        hb.new_response = raise_new || (stray_new && $urandom_range(0, 199) == 0);
        raise_new       = 1'b0;
        header_bytes_q.push_back(hb);
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    task automatic end_line(int crs);
        repeat (crs)
            put_byte(CHAR_CR);
        put_byte(CHAR_LF);
    endtask

    function automatic logic [7:0] pick_ows();
        return $urandom_range(0, 1) ? CHAR_SP : CHAR_HTAB;
    endfunction

    function automatic logic [7:0] pick_token_char();
        case ($urandom_range(0, 3))
            0:       return 8'h61 + 8'($urandom_range(0, 25));
            1:       return 8'h41 + 8'($urandom_range(0, 25));
            2:       return CHAR_0 + 8'($urandom_range(0, 9));
            default: return 8'h2D;
        endcase
    endfunction

    function automatic logic [7:0] pick_value_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 8'($urandom_range(32, 126));
        if (r < 88)
            return pick_ows();
        if (r < 94)
            return CHAR_CR;
        return 8'($urandom_range(128, 255));
    endfunction

    // Any byte but LF
    function automatic logic [7:0] pick_noise();
        logic [7:0] b;
        b = 8'($urandom_range(0, 254));
        if (b >= CHAR_LF)
            b++;
        return b;
    endfunction

    task automatic put_field();
        int name_len;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) put_byte(pick_ows());
        name_len = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
        repeat (name_len) put_byte(pick_token_char());
        repeat ($urandom_range(0, 2)) put_byte(pick_ows());
        put_byte(CHAR_COLON);
        repeat ($urandom_range(0, 3)) put_byte(pick_ows());
        repeat ($urandom_range(0, 12)) put_byte(pick_value_char());
        repeat ($urandom_range(0, 2)) put_byte(pick_ows());
        end_line($urandom_range(0, 2));
    endtask

    // Status line; when damaged, one random byte of it is replaced
    task automatic put_status(int code, bit damage);
        string s, version, gap, reason;
        int    spot;
        case ($urandom_range(0, 3))
            0:       version = "1.1";
            1:       version = "1.0";
            2:       version = "2";
            default: version = "";
        endcase
        gap = " ";
        repeat ($urandom_range(0, 2)) gap = {gap, " "};
        case ($urandom_range(0, 2))
            0:       reason = "";
            1:       reason = " OK";
            default: reason = " Some Reason";
        endcase
        s    = $sformatf("HTTP/%s%s%03d%s", version, gap, code, reason);
        spot = damage ? $urandom_range(0, s.len() - 1) : -1;
        for (int i = 0; i < s.len(); i++)
            put_byte((i == spot) ? pick_noise() : s[i]);
        end_line($urandom_range(0, 2));
    endtask

    // Response: optional 1xx sections, final status, fields with now and then a status line, blank line
    task automatic put_response();
        int n;
        raise_new = 1'b1;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n)
        begin
            put_status($urandom_range(100, 199), 1'b0);
            repeat ($urandom_range(0, 2)) put_field();
            end_line($urandom_range(0, 1));
        end
        put_status($urandom_range(200, 599), 1'b0);
        repeat ($urandom_range(1, 6))
        begin
            if ($urandom_range(0, 19) == 0)
                put_status($urandom_range(100, 599), 1'b0);
            else
                put_field();
        end
        end_line($urandom_range(0, 2));
    endtask

    task automatic put_noise_line();
        repeat ($urandom_range(0, 16)) put_byte(pick_noise());
        end_line($urandom_range(0, 2));
    endtask

    // Stimulus, reset and end of run
    initial
    begin
        int r, random_goal;
        rst_n               = 1'b0;
        hdr_ch.valid        = 1'b0;
        hdr_ch.data_byte    = '0;
        hdr_ch.new_response = 1'b0;
        line_ch.ready       = 1'b0;
        sect_informational  = 1'b0;
        sect_final_seen     = 1'b0;
        clear_line_state();

        // Directed lines
        end_line(0);                                   // bare blank line
        raise_new = 1'b1;
        put_text("HTTP/1.1 100 Continue");  end_line(1);
        put_text("X-A: b");                 end_line(1);   // inside a 1xx section
        end_line(1);
        put_text("Early: x");               end_line(0);   // before any final status
        put_text("HTTP/1.1 200 OK");        end_line(2);
        put_byte(CHAR_SP);
        put_text("Host\t:  a b \t");        end_line(1);   // trimmed name and value
        put_text("NoColon");                end_line(0);
        put_text(":value");                 end_line(0);   // empty name
        put_text("Empty:  \t");             end_line(0);   // value all whitespace
        put_text("HTTP/1.1 099 x");         end_line(0);   // code below range
        put_text("HTTP/1.1 600: y");        end_line(0);   // code above range, has a colon
        put_text("HTTP/1.0 404");           end_line(0);   // second final status
        put_text("a");
        put_byte(CHAR_CR);
        put_text("b: c");                   end_line(2);   // CR inside the line
        put_text("HTTP/1.1  5x1");          end_line(0);   // bad digit
        put_byte(8'h00);
        put_text("K:");
        put_byte(8'hFF);                    end_line(0);
        put_text("Mid");
        raise_new = 1'b1;                              // new response in mid-line
        put_text("dle: v");                 end_line(0);
        put_text("HTTP/2 599");             end_line(0);
        put_text("HTTP/1.1 199");           end_line(0);
        end_line(0);
        put_text("HTTP/1.1 100");           end_line(1);
        put_text("HTTP/1.1 201");           end_line(1);   // final straight after 1xx
        end_line(3);                                   // CRs only
        put_text("HTTPS/1 200");            end_line(0);   // wrong prefix

        // Random part, up to the byte budget of the run
        stray_new   = 1'b1;
        random_goal = 950;
        while (header_bytes_q.size() < random_goal)
        begin
            r = $urandom_range(0, 99);
            if (r < 78)
                put_response();
            else if (r < 88)
                repeat ($urandom_range(1, 3)) put_noise_line();
            else if (r < 96)
                put_status($urandom_range(0, 999), 1'b1);
            else
                put_field();
        end
        end_line(0);
        total_bytes = header_bytes_q.size();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (bytes_taken < total_bytes || expected_lines.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    // Byte driver
    always @(negedge clk)
    begin : byte_driver
        header_byte_t hb;
        if (rst_n && (hdr_taken || !hdr_ch.valid))
        begin
            if (hdr_taken)
                send_gap = pick_idle(send_calm);
            if (send_gap > 0)
            begin
                send_gap--;
                hdr_ch.valid <= 1'b0;
            end
            else if (header_bytes_q.size() > 0)
            begin
                hb = header_bytes_q.pop_front();
                hdr_ch.data_byte    <= hb.data_byte;
                hdr_ch.new_response <= hb.new_response;
                hdr_ch.valid        <= 1'b1;
            end
            else
                hdr_ch.valid <= 1'b0;
        end
    end

    // Result back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left == 0)
                stall_left = pick_idle(recv_calm);
            if (stall_left > 0)
            begin
                stall_left--;
                line_ch.ready <= 1'b0;
            end
            else
                line_ch.ready <= 1'b1;
        end
    end

    // Prediction on accepted bytes, checking on accepted results
    always @(posedge clk)
    begin : line_monitor
        bit           has_line;
        hhlp_result_t want;
        if (rst_n)
        begin
            hdr_taken <= hdr_ch.valid && hdr_ch.ready;
            if (hdr_ch.valid && hdr_ch.ready)
            begin
                bytes_taken++;
                parse_header_byte(hdr_ch.data_byte, hdr_ch.new_response, has_line, want);
                if (has_line)
                    expected_lines.push_back(want);
            end
            if (line_ch.valid && line_ch.ready)
            begin
                if (expected_lines.size() == 0)
                begin
                    $display("%0t: unexpected line, expected none, actual kind %0d",
                             $time, line_ch.line_kind);
                    mismatches++;
                end
                else
                begin
                    want = expected_lines.pop_front();
                    check_field("line_kind", want.line_kind, line_ch.line_kind);
                    check_field("status_code", want.status_code, line_ch.status_code);
                    check_field("name_start", want.name_start, line_ch.name_start);
                    check_field("name_length", want.name_length, line_ch.name_length);
                    check_field("value_start", want.value_start, line_ch.value_start);
                    check_field("value_length", want.value_length, line_ch.value_length);
                    check_field("line_overflow", want.line_overflow, line_ch.line_overflow);
                end
            end
        end
    end

endmodule
